@@ hw/rtl/intercept_time_solver_core_macros.svh @@
// ---------------------------------------------------------------------------
// Intercept time solver assertion macros
// Shared concurrent assertion forms for the solver RTL.
// ---------------------------------------------------------------------------
`ifndef INTERCEPT_TIME_SOLVER_CORE_MACROS_SVH
`define INTERCEPT_TIME_SOLVER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ITS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ITS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/itsolv_pkg.sv @@
// ---------------------------------------------------------------------------
// Intercept time solver package
// Widths and shared types for the pipelined intercept time solver.
// ---------------------------------------------------------------------------
package itsolv_pkg;

    // Field widths.
    localparam int POS_W   = 24;
    localparam int VEL_W   = 16;
    localparam int SPD_W   = 16;
    localparam int TIME_W  = 32;

    // Derived arithmetic widths.
    localparam int A_W     = 34;   // signed |V|^2 - s^2
    localparam int AMAG_W  = 33;   // |A|
    localparam int H_W     = 41;   // signed V.D
    localparam int HMAG_W  = 40;   // |H|
    localparam int C_W     = 48;   // |D|^2
    localparam int SQ_W    = 80;   // quarter discriminant
    localparam int ROOT_W  = 40;   // floor(sqrt(Q))
    localparam int N_W     = 42;   // signed root numerators
    localparam int NUM_W   = 48;   // divider numerator before scaling
    localparam int DEN_W   = 41;   // divider denominator
    localparam int FRAC_W  = 16;   // time fraction bits
    localparam int REM_W   = DEN_W + TIME_W;

    // Item context carried along the square root pipeline.
    typedef struct packed {
        logic signed [H_W-1:0] h;
        logic [AMAG_W-1:0]     aa;
        logic                  a_neg;
        logic                  a_zero;
        logic [C_W-1:0]        c;
        logic                  ok;
    } itsolv_ctx_t;

    // Division request handed to the divider pipeline.
    typedef struct packed {
        logic              found;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
    } itsolv_dreq_t;

endpackage

@@ hw/rtl/intercept_time_solver_core.sv @@
// ---------------------------------------------------------------------------
// Intercept time solver core: earliest positive intercept time per target.
// Pipeline: 82 register stages in all; 40 root and 33 divider stages set depth.
// Throughput: one transaction per cycle, unless a held result with m_tready low stalls it.
// Reset: rst_n clears all valid bits and projectile_speed to 0.
// ---------------------------------------------------------------------------
`include "intercept_time_solver_core_macros.svh"

module intercept_time_solver_core (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: projectile_speed, unsigned Q8.8.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // rel_x[23:0], rel_y[47:24], vel_x[63:48], vel_y[79:64]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // intercept_time[31:0]
    output logic        m_tuser    // reachable[0]
);
    import itsolv_pkg::*;

    localparam int PRE_STAGES = 6;

    logic                   ce;
    logic [SPD_W-1:0]       speed_reg;
    logic [PRE_STAGES-1:0]  v_reg;

    // Input field views.
    logic signed [POS_W-1:0] in_dx, in_dy;
    logic signed [VEL_W-1:0] in_vx, in_vy;

    // Stage 1 products.
    logic signed [31:0]       p_vxx, p_vyy;
    logic signed [39:0]       p_hx, p_hy;
    logic signed [47:0]       p_dxx, p_dyy;
    logic [31:0]              p_ss;
    logic [30:0]              vxx_reg, vyy_reg;
    logic [31:0]              ss_reg;
    logic signed [39:0]       hx_reg, hy_reg;
    logic [46:0]              dxx_reg, dyy_reg;

    // Stage 2 sums.
    logic signed [A_W-1:0]    a2_reg;
    logic signed [H_W-1:0]    h2_reg;
    logic [C_W-1:0]           c2_reg;

    // Stage 3 magnitudes, stage 4 partial products, stage 5 wide products.
    logic signed [A_W-1:0]    a_neg_val;
    logic signed [H_W-1:0]    h_neg_val;
    itsolv_ctx_t              ctx3_next;
    itsolv_ctx_t              ctx3_reg, ctx4_reg, ctx5_reg;
    logic [HMAG_W-1:0]        ah3_reg;
    logic [39:0]              pp_hh_reg, pp_hm_reg, pp_ll_reg;
    logic [56:0]              pp_acl_reg, pp_ach_reg;
    logic [SQ_W-1:0]          hh5_reg;
    logic [SQ_W:0]            ac5_reg;

    // Stage 6 discriminant.
    logic [SQ_W+1:0]          disc_diff;
    logic [SQ_W-1:0]          q6_reg;
    itsolv_ctx_t              ctx6_next;
    itsolv_ctx_t              ctx6_reg;

    // Square root outputs.
    logic                     sq_valid;
    logic [ROOT_W-1:0]        sq_root;
    itsolv_ctx_t              sq_ctx;

    // Stage 7 numerators, stage 8 selection.
    logic                     v7_reg, v8_reg;
    logic signed [N_W-1:0]    n0_reg, n1_reg;
    logic signed [N_W-1:0]    neg_h;
    logic [DEN_W-1:0]         negh2_reg;
    itsolv_ctx_t              ctx7_reg;
    itsolv_dreq_t             sel_req, req8_reg;

    // Divider outputs and result register.
    logic                     dv_valid, dv_found, dv_sat;
    logic [TIME_W-1:0]        dv_quo;
    logic                     out_valid_reg;
    logic [TIME_W-1:0]        out_time_reg;
    logic                     out_reach_reg;

    // The whole pipeline advances unless the result register is held.
    assign ce        = !out_valid_reg || m_tready;
    assign s_tready  = ce;
    assign cfg_ready = 1'b1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            speed_reg <= '0;
        else if (cfg_valid && cfg_ready)
            speed_reg <= cfg_data;
    end

    assign in_dx = s_tdata[23:0];
    assign in_dy = s_tdata[47:24];
    assign in_vx = s_tdata[63:48];
    assign in_vy = s_tdata[79:64];

    // Stage 1: all component products.
    assign p_vxx = in_vx * in_vx;
    assign p_vyy = in_vy * in_vy;
    assign p_ss  = 32'(speed_reg) * 32'(speed_reg);
    assign p_hx  = in_vx * in_dx;
    assign p_hy  = in_vy * in_dy;
    assign p_dxx = in_dx * in_dx;
    assign p_dyy = in_dy * in_dy;

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (ce)
            v_reg <= {v_reg[PRE_STAGES-2:0], s_tvalid};
    end

    assign a_neg_val = -a2_reg;
    assign h_neg_val = -h2_reg;
    assign disc_diff = {2'b00, hh5_reg} - {1'b0, ac5_reg};

    // Context of stage 3 and the discriminant check of stage 6.
    always_comb
    begin
        ctx3_next.h      = h2_reg;
        ctx3_next.aa     = a2_reg[A_W-1] ? a_neg_val[AMAG_W-1:0] : a2_reg[AMAG_W-1:0];
        ctx3_next.a_neg  = a2_reg[A_W-1];
        ctx3_next.a_zero = (a2_reg == '0);
        ctx3_next.c      = c2_reg;
        ctx3_next.ok     = 1'b0;

        ctx6_next    = ctx5_reg;
        ctx6_next.ok = ctx5_reg.a_neg || !disc_diff[SQ_W+1];
    end

    // Front stages: products, sums, magnitudes, partial products, discriminant.
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            vxx_reg <= p_vxx[30:0];
            vyy_reg <= p_vyy[30:0];
            ss_reg  <= p_ss;
            hx_reg  <= p_hx;
            hy_reg  <= p_hy;
            dxx_reg <= p_dxx[46:0];
            dyy_reg <= p_dyy[46:0];

            a2_reg <= $signed({3'b000, vxx_reg}) + $signed({3'b000, vyy_reg})
                    - $signed({2'b00, ss_reg});
            h2_reg <= $signed({hx_reg[39], hx_reg}) + $signed({hy_reg[39], hy_reg});
            c2_reg <= {1'b0, dxx_reg} + {1'b0, dyy_reg};

            ctx3_reg <= ctx3_next;
            ah3_reg  <= h2_reg[H_W-1] ? h_neg_val[HMAG_W-1:0] : h2_reg[HMAG_W-1:0];

            ctx4_reg   <= ctx3_reg;
            pp_hh_reg  <= 40'(ah3_reg[39:20]) * 40'(ah3_reg[39:20]);
            pp_hm_reg  <= 40'(ah3_reg[39:20]) * 40'(ah3_reg[19:0]);
            pp_ll_reg  <= 40'(ah3_reg[19:0]) * 40'(ah3_reg[19:0]);
            pp_acl_reg <= 57'(ctx3_reg.aa) * 57'(ctx3_reg.c[23:0]);
            pp_ach_reg <= 57'(ctx3_reg.aa) * 57'(ctx3_reg.c[47:24]);

            ctx5_reg <= ctx4_reg;
            hh5_reg  <= {pp_hh_reg, 40'b0} + SQ_W'({pp_hm_reg, 21'b0}) + SQ_W'(pp_ll_reg);
            ac5_reg  <= {pp_ach_reg, 24'b0} + (SQ_W + 1)'(pp_acl_reg);

            ctx6_reg <= ctx6_next;
            q6_reg   <= ctx5_reg.a_neg ? SQ_W'({1'b0, hh5_reg} + ac5_reg)
                                       : disc_diff[SQ_W-1:0];
        end
    end

    itsolv_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (ce),
        .in_valid  (v_reg[PRE_STAGES-1]),
        .q         (q6_reg),
        .in_ctx    (ctx6_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_ctx   (sq_ctx)
    );

    assign neg_h = -$signed({sq_ctx.h[H_W-1], sq_ctx.h});

    // Stage 7: both root numerators and the linear denominator.
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ctx7_reg  <= sq_ctx;
            n0_reg    <= neg_h + $signed({2'b00, sq_root});
            n1_reg    <= neg_h - $signed({2'b00, sq_root});
            negh2_reg <= {neg_h[HMAG_W-1:0], 1'b0};
        end
    end

    // Stage 8: pick the numerator of the smallest positive root.
    always_comb
    begin
        sel_req.found = 1'b0;
        sel_req.num   = ctx7_reg.c;
        sel_req.den   = DEN_W'(ctx7_reg.aa);
        priority if (ctx7_reg.a_zero)
        begin
            sel_req.found = ctx7_reg.h[H_W-1] && (ctx7_reg.c != '0);
            sel_req.den   = negh2_reg;
        end
        else if (!ctx7_reg.ok)
        begin
            sel_req.found = 1'b0;
        end
        else if (!ctx7_reg.a_neg)
        begin
            if (n1_reg > 0)
            begin
                sel_req.found = 1'b1;
                sel_req.num   = NUM_W'(n1_reg);
            end
            else if (n0_reg > 0)
            begin
                sel_req.found = 1'b1;
                sel_req.num   = NUM_W'(n0_reg);
            end
            else
                sel_req.found = 1'b0;
        end
        else
        begin
            if (n0_reg < 0)
            begin
                sel_req.found = 1'b1;
                sel_req.num   = NUM_W'(-n0_reg);
            end
            else if (n1_reg < 0)
            begin
                sel_req.found = 1'b1;
                sel_req.num   = NUM_W'(-n1_reg);
            end
            else
                sel_req.found = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else if (ce)
        begin
            v7_reg <= sq_valid;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            req8_reg <= sel_req;
    end

    itsolv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (ce),
        .in_valid  (v8_reg),
        .req       (req8_reg),
        .out_valid (dv_valid),
        .out_found (dv_found),
        .out_sat   (dv_sat),
        .quo       (dv_quo)
    );

    // Result register: saturate, or zero when unreachable.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ce)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_reach_reg <= dv_found;
            out_time_reg  <= !dv_found ? '0 : (dv_sat ? '1 : dv_quo);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_time_reg;
    assign m_tuser  = out_reach_reg;

    `ITS_ASSERT_NOW(a_unreach_zero, m_tvalid && !m_tuser, m_tdata == '0, "unreachable result with nonzero time")
    `ITS_ASSERT_NEXT(a_stall_holds, !ce, m_tvalid, "pipeline stalled without a held result")
    `ITS_ASSERT_NEXT(a_div_to_out, ce && dv_valid, m_tvalid, "divider result lost before output")

endmodule

@@ hw/rtl/itsolv_sqrt.sv @@
// ---------------------------------------------------------------------------
// Intercept time solver square root
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ---------------------------------------------------------------------------
module itsolv_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [itsolv_pkg::SQ_W-1:0]   q,
    input  itsolv_pkg::itsolv_ctx_t       in_ctx,
    output logic                          out_valid,
    output logic [itsolv_pkg::ROOT_W-1:0] root,
    output itsolv_pkg::itsolv_ctx_t       out_ctx
);
    import itsolv_pkg::*;

    logic [ROOT_W-1:0] vld_reg;
    logic [SQ_W-1:0]   rem_reg   [ROOT_W];
    logic [SQ_W-1:0]   rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];
    itsolv_ctx_t       ctx_reg   [ROOT_W];

    // Each stage tries one root bit against the running remainder.
    always_comb
    begin
        logic [SQ_W-1:0]   rem_in;
        logic [SQ_W-1:0]   trial;
        logic [ROOT_W-1:0] root_in;
        int                prev;
        for (int k = 0; k < ROOT_W; k++)
        begin
            prev = (k == 0) ? 0 : k - 1;
            if (k == 0)
            begin
                rem_in  = q;
                root_in = '0;
            end
            else
            begin
                rem_in  = rem_reg[prev];
                root_in = root_reg[prev];
            end
            trial = (SQ_W'(root_in) << (ROOT_W - k))
                  | (SQ_W'(1) << (2 * (ROOT_W - 1 - k)));
            if (rem_in >= trial)
            begin
                rem_next[k]  = rem_in - trial;
                root_next[k] = root_in | (ROOT_W'(1) << (ROOT_W - 1 - k));
            end
            else
            begin
                rem_next[k]  = rem_in;
                root_next[k] = root_in;
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[ROOT_W-2:0], in_valid};
    end

    // Stage data registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= in_ctx;
            for (int k = 0; k < ROOT_W; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
            for (int k = 1; k < ROOT_W; k++)
                ctx_reg[k] <= ctx_reg[k-1];
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_ctx   = ctx_reg[ROOT_W-1];

endmodule

@@ hw/rtl/itsolv_div.sv @@
// ---------------------------------------------------------------------------
// Intercept time solver divider
// Pipelined restoring divider producing a saturated Q16.16 quotient.
// ---------------------------------------------------------------------------
module itsolv_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  itsolv_pkg::itsolv_dreq_t      req,
    output logic                          out_valid,
    output logic                          out_found,
    output logic                          out_sat,
    output logic [itsolv_pkg::TIME_W-1:0] quo
);
    import itsolv_pkg::*;

    localparam int SAT_W = NUM_W + 9;

    // Setup stage registers.
    logic              s_vld_reg;
    logic              s_found_reg;
    logic              s_sat_reg;
    logic [REM_W-1:0]  s_rem_reg;
    logic [DEN_W-1:0]  s_den_reg;

    // Quotient step registers.
    logic [TIME_W-1:0] vld_reg;
    logic [TIME_W-1:0] found_reg;
    logic [TIME_W-1:0] sat_reg;
    logic [REM_W-1:0]  rem_reg  [TIME_W];
    logic [REM_W-1:0]  rem_next [TIME_W];
    logic [DEN_W-1:0]  den_reg  [TIME_W];
    logic [TIME_W-1:0] quo_reg  [TIME_W];
    logic [TIME_W-1:0] quo_next [TIME_W];

    // A quotient of 2^32 or more saturates; otherwise the remainder starts
    // below den << 32 and every step yields one quotient bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_vld_reg <= 1'b0;
        else if (en)
            s_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_found_reg <= req.found;
            s_sat_reg   <= SAT_W'(req.num) >= {req.den, {FRAC_W{1'b0}}};
            s_rem_reg   <= REM_W'({req.num, {FRAC_W{1'b0}}});
            s_den_reg   <= req.den;
        end
    end

    // Restoring step per stage.
    always_comb
    begin
        logic [REM_W-1:0]  rem_in;
        logic [REM_W-1:0]  trial;
        logic [TIME_W-1:0] quo_in;
        logic [DEN_W-1:0]  den_in;
        int                prev;
        for (int k = 0; k < TIME_W; k++)
        begin
            prev = (k == 0) ? 0 : k - 1;
            if (k == 0)
            begin
                rem_in = s_rem_reg;
                quo_in = '0;
                den_in = s_den_reg;
            end
            else
            begin
                rem_in = rem_reg[prev];
                quo_in = quo_reg[prev];
                den_in = den_reg[prev];
            end
            trial = REM_W'(den_in) << (TIME_W - 1 - k);
            if (rem_in >= trial)
            begin
                rem_next[k] = rem_in - trial;
                quo_next[k] = quo_in | (TIME_W'(1) << (TIME_W - 1 - k));
            end
            else
            begin
                rem_next[k] = rem_in;
                quo_next[k] = quo_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[TIME_W-2:0], s_vld_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            found_reg  <= {found_reg[TIME_W-2:0], s_found_reg};
            sat_reg    <= {sat_reg[TIME_W-2:0], s_sat_reg};
            den_reg[0] <= s_den_reg;
            for (int k = 0; k < TIME_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= quo_next[k];
            end
            for (int k = 1; k < TIME_W; k++)
                den_reg[k] <= den_reg[k-1];
        end
    end

    assign out_valid = vld_reg[TIME_W-1];
    assign out_found = found_reg[TIME_W-1];
    assign out_sat   = sat_reg[TIME_W-1];
    assign quo       = quo_reg[TIME_W-1];

endmodule

@@ tb/sv/testbench.sv @@
// ---------------------------------------------------------------------------
// Intercept time solver testbench
// Streams target tracks into the solver under several projectile speeds.
// Each result is checked against a bit-exact predictor of the intercept time.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import itsolv_pkg::*;

    // One target track as it travels on the input stream.
    typedef struct packed {
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [POS_W-1:0] rel_y;
        logic signed [POS_W-1:0] rel_x;
    } track_t;

    // One solved intercept.
    typedef struct {
        logic [TIME_W-1:0] itime;
        logic              reach;
    } intercept_t;

    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 240;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;

    track_t     track_queue[$];
    intercept_t intercept_queue[$];
    logic [SPD_W-1:0] speed_setting;
    int error_count    = 0;
    int cycle_count    = 0;
    int accepted_count = 0;
    int gap_left;
    int burst_left;
    int hold_left;
    bit hold_done;
    int stall_mode;

    intercept_time_solver_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // rel_x, rel_y, vel_x, vel_y from the lowest bit up
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // intercept_time
        .m_tuser   (m_tuser)    // reachable
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Integer square root, floor, of a nonnegative value below 2^84.
    function automatic logic [63:0] isqrt(input logic [127:0] q);
        logic [63:0] r;
        logic [63:0] cand;
        r = 64'd0;
        for (int b = 41; b >= 0; b--)
        begin
            cand = r | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= q)
                r = cand;
        end
        return r;
    endfunction

    // Quotient clipped to the time range.
    function automatic logic [TIME_W-1:0] clip_div(input logic [127:0] num,
                                                    input logic [127:0] den);
        logic [127:0] q;
        q = num / den;
        return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    // Earliest positive intercept for one track at the current speed.
    function automatic intercept_t solve_intercept(input track_t t,
                                                   input logic [SPD_W-1:0] spd);
        longint dx, dy, vx, vy, s, a, h, c, root, n;
        logic signed [127:0] qd;
        logic [TIME_W-1:0] tm;
        intercept_t res;
        dx = t.rel_x;
        dy = t.rel_y;
        vx = t.vel_x;
        vy = t.vel_y;
        s = {48'd0, spd};
        a = vx * vx + vy * vy - s * s;
        h = vx * dx + vy * dy;
        c = dx * dx + dy * dy;
        res.itime = '0;
        res.reach = 1'b0;
        if (a == 0)
        begin
            // Linear case: one root at -c / 2h.
            if (h < 0 && c > 0)
            begin
                res.itime = clip_div({64'd0, c} << 16, {64'd0, -2 * h});
                res.reach = 1'b1;
            end
        end
        else
        begin
            qd = 128'(signed'(h)) * 128'(signed'(h)) - 128'(signed'(a)) * 128'(signed'(c));
            if (qd >= 0)
            begin
                root = isqrt(qd);
                for (int k = 0; k < 2; k++)
                begin
                    n = (k == 0) ? (-h + root) : (-h - root);
                    if (n != 0 && ((n > 0) == (a > 0)))
                    begin
                        tm = clip_div({64'd0, (n < 0 ? -n : n)} << 16,
                                      {64'd0, (a < 0 ? -a : a)});
                        if (!res.reach || tm < res.itime)
                            res.itime = tm;
                        res.reach = 1'b1;
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // Append a track to the pending stimulus.
    task automatic add_track(input track_t t);
        track_queue.insert(track_queue.size(), t);
    endtask

    // Append a predicted result to the expected list.
    task automatic add_expected(input intercept_t r);
        intercept_queue.insert(intercept_queue.size(), r);
    endtask

    function automatic track_t make_track(input int rx, input int ry,
                                          input int vx, input int vy);
        track_t t;
        t.rel_x = rx[POS_W-1:0];
        t.rel_y = ry[POS_W-1:0];
        t.vel_x = vx[VEL_W-1:0];
        t.vel_y = vy[VEL_W-1:0];
        return t;
    endfunction

    // Random track: mostly full range, some moderate, some as fast as the projectile.
    function automatic track_t random_track();
        track_t t;
        int sel;
        sel = $urandom_range(0, 3);
        t = 80'({$urandom, $urandom, $urandom});
        if (sel == 0)
        begin
            t.rel_x = $signed(t.rel_x) >>> $urandom_range(0, 20);
            t.rel_y = $signed(t.rel_y) >>> $urandom_range(0, 20);
            t.vel_x = $signed(t.vel_x) >>> $urandom_range(0, 14);
            t.vel_y = $signed(t.vel_y) >>> $urandom_range(0, 14);
        end
        else if (sel == 1)
        begin
            // Target as fast as the projectile along one axis.
            t.vel_x = speed_setting;
            t.vel_y = '0;
        end
        return t;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            gap_left   <= 0;
            burst_left <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                add_expected(solve_intercept(track_t'(s_tdata), speed_setting));
                accepted_count <= accepted_count + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (track_queue.size() > 0)
                begin
                    s_tdata  <= track_queue.pop_front();
                    s_tvalid <= 1'b1;
                    if (burst_left <= 0)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: its own stall pattern plus one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if (!hold_done && accepted_count >= 300)
            begin
                hold_done <= 1'b1;
                hold_left <= 400;
                m_tready  <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 63) == 0)
                    stall_mode <= $urandom_range(0, 2);
                case (stall_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 1) == 0);
                endcase
            end
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        intercept_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (intercept_queue.size() == 0)
                report_mismatch("unexpected result", m_tdata, 32'd0);
            else
            begin
                want = intercept_queue.pop_front();
                if (m_tdata !== want.itime)
                    report_mismatch("intercept_time", m_tdata, want.itime);
                if (m_tuser !== want.reach)
                    report_mismatch("reachable", {31'd0, m_tuser}, {31'd0, want.reach});
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_speed(input logic [SPD_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        speed_setting = v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (track_queue.size() > 0 || s_tvalid || intercept_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Phase sequencing: speed setting, directed tracks, random tracks.
    initial
    begin
        logic [SPD_W-1:0] speeds[5];
        speed_setting  = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        rst_n          = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        speeds[0] = 16'd0;
        speeds[1] = 16'hFFFF;
        speeds[2] = 16'd256;
        speeds[3] = 16'($urandom);
        speeds[4] = 16'($urandom_range(1, 1024));
        for (int p = 0; p < 5; p++)
        begin
            write_speed(speeds[p]);
            if (p < 3)
            begin
                // Extremes, degenerate, linear, tiny and saturating cases.
                add_track(make_track(0, 0, 0, 0));
                add_track(make_track(8388607, 8388607, 32767, 32767));
                add_track(make_track(-8388608, -8388608, -32768, -32768));
                add_track(make_track(-1000, 0, 256, 0));
                add_track(make_track(1000, 0, 0, 256));
                add_track(make_track(1, 0, 0, 0));
                add_track(make_track(8388607, 0, 255, 0));
                add_track(make_track(-8388608, 1, 256, -1));
            end
            for (int i = 0; i < RANDOM_ITEMS; i++)
                add_track(random_track());
            // The next phase waits until every result of this one has come.
            wait_idle();
        end
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
